### design/crc_checked_frame_decoder_assert.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef CRC_CHECKED_FRAME_DECODER_ASSERT_SVH
`define CRC_CHECKED_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cfd_pkg.sv
// Shared types, codes, header layout and CRC-32C helper for the frame decoder.
package cfd_pkg;

  // Header layout: 32 bytes, little-endian fields.
  localparam int HDR_BYTES   = 32;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam int OFF_MAGIC   = 0;
  localparam int OFF_VERSION = 4;
  localparam int OFF_OPCODE  = 6;
  localparam int OFF_REQ_ID  = 8;
  localparam int OFF_LEN     = 16;
  localparam int OFF_FLAGS   = 20;
  localparam int OFF_RSVD    = 22;
  localparam int OFF_PCRC    = 24;
  localparam int OFF_HCRC    = 28;

  // Opcodes at or above this value are never known.
  localparam int KNOWN_OPCODES = 64;

  // CRC-32C, reflected form.
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MAGIC       = 3'd0,
    REG_MIN_VERSION       = 3'd1,
    REG_MAX_VERSION       = 3'd2,
    REG_KNOWN_OPCODE_MASK = 3'd3,
    REG_LEN_LIMIT         = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ERROR   = 2'd2
  } event_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_MAGIC       = 4'd1,
    ST_HDR_CRC     = 4'd2,
    ST_RESERVED    = 4'd3,
    ST_VERSION     = 4'd4,
    ST_OPCODE      = 4'd5,
    ST_TOO_LONG    = 4'd6,
    ST_PAYLOAD_CRC = 4'd7,
    ST_EMPTY_CRC   = 4'd8
  } status_t;

  // Header bytes; a packed slice [hi:lo] reads a little-endian field directly.
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  // One result item as held in the output register.
  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  status;
    logic [15:0] version;
    logic [15:0] opcode;
    logic [63:0] req_ident;
    logic [31:0] body_len;
    logic [15:0] flags;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } res_t;

  // One byte of CRC-32C, bit by bit over eight steps.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

### design/cfd_ifs.sv
// Stream interfaces of the frame decoder: byte input and result output.
interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface cfd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [3:0]  status;
  logic [15:0] version;
  logic [15:0] opcode;
  logic [63:0] req_ident;
  logic [31:0] body_len;
  logic [15:0] flags;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  modport source (output valid, output event_res, output status, output version,
                  output opcode, output req_ident, output body_len,
                  output flags, output payload_byte, output last_of_frame,
                  input ready);
  modport sink (input valid, input event_res, input status, input version,
                input opcode, input req_ident, input body_len,
                input flags, input payload_byte, input last_of_frame,
                output ready);
endinterface

### design/crc_checked_frame_decoder.sv
// Top level: length-prefixed frame decoder with CRC-32C header and payload checks.
//
//   Channel      Direction  Content                         Transfer when
//   frame_bytes  sink       one frame byte                  valid && ready
//   results      source     header, payload or error item   valid && ready
//   cfg_*        write      register index and data         cfg_we high
//
// One byte per cycle sustained while results are taken; a byte enters the input register
// at its transfer, and its result is then loaded from there into the result register.
// The byte-wide CRC-32C update and the header checks sit between those registers.
// Reset (rst, synchronous) clears control state and loads register defaults.
// A stalled result holds the output register; the input register can still take a
// byte if it is empty, then ready drops until the result is taken.
`include "crc_checked_frame_decoder_assert.svh"

module crc_checked_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  cfd_byte_if.sink                       frame_bytes,
  cfd_result_if.source                   results,
  input  logic                           cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfd_pkg::*;

  // Configuration registers.
  logic [31:0] frame_magic;
  logic [15:0] min_version;
  logic [15:0] max_version;
  logic [63:0] known_opcode_mask;
  logic [31:0] len_limit;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Decoder state.
  hdr_t        header_store;
  logic [31:0] byte_position;
  logic [31:0] crc_acc;
  logic        in_payload;
  logic        error_latched;

  logic [31:0] byte_position_next;
  logic [31:0] crc_acc_next;
  logic        in_payload_next;
  logic        error_latched_next;

  // Result register.
  logic out_valid;
  res_t res;
  res_t res_next;
  logic emit;

  logic advance;

  // Decode helpers.
  hdr_t        hdr_cur;
  logic [31:0] crc_upd;
  logic [31:0] pos_inc;
  logic        header_done;
  logic [15:0] hdr_version;
  logic [15:0] hdr_opcode;
  logic [31:0] hdr_len;
  logic [31:0] hdr_pcrc;
  logic        opcode_known;
  status_t     hdr_status;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic       <= 32'd0;
      min_version       <= 16'd1;
      max_version       <= 16'd1;
      known_opcode_mask <= 64'd0;
      len_limit         <= 32'd1048576;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_MAGIC:       frame_magic       <= cfg_data[31:0];
        REG_MIN_VERSION:       min_version       <= cfg_data[15:0];
        REG_MAX_VERSION:       max_version       <= cfg_data[15:0];
        REG_KNOWN_OPCODE_MASK: known_opcode_mask <= cfg_data;
        REG_LEN_LIMIT:         len_limit         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves when the result register is free or being drained.
  assign advance           = s1_valid && (!out_valid || results.ready);
  assign frame_bytes.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_bytes.valid && frame_bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_bytes.valid && frame_bytes.ready) begin
      s1_byte <= frame_bytes.data_byte;
    end
  end

  // Header view including the byte now being written; payload bytes leave it alone.
  always_comb begin
    hdr_cur = header_store;
    if (!in_payload) begin
      hdr_cur[byte_position[HDR_IDX_W-1:0]] = s1_byte;
    end
  end

  assign crc_upd     = crc32c_byte(crc_acc, s1_byte);
  assign pos_inc     = byte_position + 32'd1;
  assign header_done = &byte_position[HDR_IDX_W-1:0];

  assign hdr_version = hdr_cur[OFF_VERSION+1:OFF_VERSION];
  assign hdr_opcode  = hdr_cur[OFF_OPCODE+1:OFF_OPCODE];
  assign hdr_len     = hdr_cur[OFF_LEN+3:OFF_LEN];
  assign hdr_pcrc    = hdr_cur[OFF_PCRC+3:OFF_PCRC];

  assign opcode_known = (hdr_opcode < 16'(KNOWN_OPCODES)) &&
                        known_opcode_mask[hdr_opcode[5:0]];

  // Header checks in priority order; the header CRC is final before byte 28.
  always_comb begin
    if (hdr_cur[OFF_MAGIC+3:OFF_MAGIC] != frame_magic) begin
      hdr_status = ST_MAGIC;
    end else if (hdr_cur[OFF_HCRC+3:OFF_HCRC] != (crc_acc ^ CRC_INIT)) begin
      hdr_status = ST_HDR_CRC;
    end else if (hdr_cur[OFF_RSVD+1:OFF_RSVD] != 16'd0) begin
      hdr_status = ST_RESERVED;
    end else if (hdr_version < min_version || hdr_version > max_version) begin
      hdr_status = ST_VERSION;
    end else if (!opcode_known) begin
      hdr_status = ST_OPCODE;
    end else if (hdr_len > len_limit) begin
      hdr_status = ST_TOO_LONG;
    end else if (hdr_len == 32'd0 && hdr_pcrc != 32'd0) begin
      hdr_status = ST_EMPTY_CRC;
    end else begin
      hdr_status = ST_OK;
    end
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    byte_position_next = byte_position;
    crc_acc_next       = crc_acc;
    in_payload_next    = in_payload;
    error_latched_next = error_latched;
    res_next           = '0;
    emit               = 1'b0;

    if (error_latched) begin
      // Dropped with no result.
      emit = 1'b0;
    end else if (in_payload) begin
      emit                  = 1'b1;
      res_next.event_res    = EV_PAYLOAD;
      res_next.payload_byte = s1_byte;
      byte_position_next    = pos_inc;
      crc_acc_next          = crc_upd;
      if (pos_inc >= hdr_len) begin
        res_next.last_of_frame = 1'b1;
        if ((crc_upd ^ CRC_INIT) != hdr_pcrc) begin
          res_next.status    = ST_PAYLOAD_CRC;
          error_latched_next = 1'b1;
        end
        in_payload_next    = 1'b0;
        byte_position_next = 32'd0;
        crc_acc_next       = CRC_INIT;
      end
    end else begin
      byte_position_next = pos_inc;
      if (byte_position[HDR_IDX_W-1:0] < 5'(OFF_HCRC)) begin
        crc_acc_next = crc_upd;
      end
      if (header_done) begin
        emit               = 1'b1;
        byte_position_next = 32'd0;
        crc_acc_next       = CRC_INIT;
        if (hdr_status != ST_OK) begin
          res_next.event_res     = EV_ERROR;
          res_next.status        = hdr_status;
          res_next.last_of_frame = 1'b1;
          error_latched_next     = 1'b1;
        end else begin
          res_next.event_res     = EV_HEADER;
          res_next.version       = hdr_version;
          res_next.opcode        = hdr_opcode;
          res_next.req_ident     = hdr_cur[OFF_REQ_ID+7:OFF_REQ_ID];
          res_next.body_len      = hdr_len;
          res_next.flags         = hdr_cur[OFF_FLAGS+1:OFF_FLAGS];
          res_next.last_of_frame = (hdr_len == 32'd0);
          in_payload_next        = (hdr_len != 32'd0);
        end
      end
    end
  end

  // Decoder state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 32'd0;
      crc_acc       <= CRC_INIT;
      in_payload    <= 1'b0;
      error_latched <= 1'b0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      crc_acc       <= crc_acc_next;
      in_payload    <= in_payload_next;
      error_latched <= error_latched_next;
      out_valid     <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Header bytes and result payload.
  always_ff @(posedge clk) begin
    if (advance && !error_latched && !in_payload) begin
      header_store[byte_position[HDR_IDX_W-1:0]] <= s1_byte;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.event_res     = res.event_res;
  assign results.status        = res.status;
  assign results.version       = res.version;
  assign results.opcode        = res.opcode;
  assign results.req_ident     = res.req_ident;
  assign results.body_len      = res.body_len;
  assign results.flags         = res.flags;
  assign results.payload_byte  = res.payload_byte;
  assign results.last_of_frame = res.last_of_frame;

  // Checks on decoder state and results.
  `CFD_ASSERT_NEXT(a_error_sticky, error_latched, error_latched, "error flag cleared")
  `CFD_ASSERT_IMPLY(a_error_not_payload, error_latched, !in_payload, "payload after error")
  `CFD_ASSERT_IMPLY(a_header_pos_range, !in_payload,
                    byte_position[31:HDR_IDX_W] == '0, "header position out of range")
  `CFD_ASSERT_IMPLY(a_header_ok, out_valid && res.event_res == EV_HEADER,
                    res.status == ST_OK, "header result with error status")
  `CFD_ASSERT_IMPLY(a_error_ends_frame, out_valid && res.event_res == EV_ERROR,
                    res.last_of_frame && res.status != ST_OK, "error report malformed")

endmodule

### test/cfd_frame_checker.sv
// Checker for the frame decoder: predicts each result from the byte stream and compares it.
`timescale 1ns / 100ps

module cfd_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  cfd_byte_if                            byte_mon,
  cfd_result_if                          res_mon,
  input  logic                           cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             results_due,
  output int                             results_checked
);
  import cfd_pkg::*;

  // Register copies as the decoder should hold them.
  logic [31:0] magic_cfg;
  logic [15:0] min_ver_cfg;
  logic [15:0] max_ver_cfg;
  logic [63:0] opcode_mask_cfg;
  logic [31:0] len_limit_cfg;

  // Decoder state as predicted.
  hdr_t        hdr;
  logic [31:0] pos;
  logic [31:0] crc_run;
  logic        in_payload;
  logic        stuck;

  res_t frame_events_due[$];

  // CRC-32C, reflected, one byte.
  function automatic logic [31:0] crc32c_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Header checks in priority order; crc_run still holds the header CRC here.
  function automatic status_t header_verdict();
    if (hdr[3:0] != magic_cfg) return ST_MAGIC;
    if (hdr[31:28] != ~crc_run) return ST_HDR_CRC;
    if (hdr[23:22] != 16'd0) return ST_RESERVED;
    if (hdr[5:4] < min_ver_cfg || hdr[5:4] > max_ver_cfg) return ST_VERSION;
    if (hdr[7:6] >= KNOWN_OPCODES || !opcode_mask_cfg[hdr[6][5:0]]) return ST_OPCODE;
    if (hdr[19:16] > len_limit_cfg) return ST_TOO_LONG;
    return ST_OK;
  endfunction

  // Advances the predicted state by one accepted byte and queues any result.
  task automatic decode_byte(input logic [7:0] b);
    res_t    r;
    status_t verdict;
    if (stuck) return;
    r = '0;
    if (in_payload) begin
      crc_run = crc32c_next(crc_run, b);
      pos = pos + 1;
      r.event_res = EV_PAYLOAD;
      r.status = ST_OK;
      r.payload_byte = b;
      if (pos >= hdr[19:16]) begin
        r.last_of_frame = 1'b1;
        if (~crc_run != hdr[27:24]) begin
          r.status = ST_PAYLOAD_CRC;
          stuck = 1'b1;
        end
        in_payload = 1'b0;
        pos = 0;
        crc_run = CRC_INIT;
      end
      frame_events_due.push_back(r);
      return;
    end
    // Header collection; the CRC covers everything before the header CRC field.
    hdr[pos[4:0]] = b;
    if (pos < OFF_HCRC) crc_run = crc32c_next(crc_run, b);
    pos = pos + 1;
    if (pos < HDR_BYTES) return;
    verdict = header_verdict();
    pos = 0;
    crc_run = CRC_INIT;
    if (verdict == ST_OK && hdr[19:16] == 32'd0 && hdr[27:24] != 32'd0)
      verdict = ST_EMPTY_CRC;
    if (verdict != ST_OK) begin
      r.event_res = EV_ERROR;
      r.status = verdict;
      r.last_of_frame = 1'b1;
      stuck = 1'b1;
    end else begin
      r.event_res = EV_HEADER;
      r.status = ST_OK;
      r.version = hdr[5:4];
      r.opcode = hdr[7:6];
      r.req_ident = hdr[15:8];
      r.body_len = hdr[19:16];
      r.flags = hdr[21:20];
      r.last_of_frame = (hdr[19:16] == 32'd0);
      in_payload = (hdr[19:16] != 32'd0);
    end
    frame_events_due.push_back(r);
  endtask

  function automatic string show(res_t r);
    return $sformatf("ev=%0d st=%0d ver=%h opc=%h id=%h len=%h flags=%h byte=%h last=%b",
                     r.event_res, r.status, r.version, r.opcode, r.req_ident,
                     r.body_len, r.flags, r.payload_byte, r.last_of_frame);
  endfunction

  // Compares one result transfer against the oldest expectation.
  task automatic check_result();
    res_t  got;
    res_t  want;
    string diffs;
    got.event_res = res_mon.event_res;
    got.status = res_mon.status;
    got.version = res_mon.version;
    got.opcode = res_mon.opcode;
    got.req_ident = res_mon.req_ident;
    got.body_len = res_mon.body_len;
    got.flags = res_mon.flags;
    got.payload_byte = res_mon.payload_byte;
    got.last_of_frame = res_mon.last_of_frame;
    results_checked++;
    if (frame_events_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing expected: %s", results_checked, show(got));
      return;
    end
    want = frame_events_due.pop_front();
    diffs = "";
    if (got.event_res !== want.event_res) diffs = {diffs, " event_res"};
    if (got.status !== want.status) diffs = {diffs, " status"};
    if (got.version !== want.version) diffs = {diffs, " version"};
    if (got.opcode !== want.opcode) diffs = {diffs, " opcode"};
    if (got.req_ident !== want.req_ident) diffs = {diffs, " req_ident"};
    if (got.body_len !== want.body_len) diffs = {diffs, " body_len"};
    if (got.flags !== want.flags) diffs = {diffs, " flags"};
    if (got.payload_byte !== want.payload_byte) diffs = {diffs, " payload_byte"};
    if (got.last_of_frame !== want.last_of_frame) diffs = {diffs, " last_of_frame"};
    if (diffs != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d wrong in%s", results_checked, diffs);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endtask

  // Watch configuration writes and both channels on every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      magic_cfg = 32'd0;
      min_ver_cfg = 16'd1;
      max_ver_cfg = 16'd1;
      opcode_mask_cfg = 64'd0;
      len_limit_cfg = 32'd1048576;
      hdr = '0;
      pos = 0;
      crc_run = CRC_INIT;
      in_payload = 1'b0;
      stuck = 1'b0;
      frame_events_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_MAGIC:       magic_cfg = cfg_data[31:0];
          REG_MIN_VERSION:       min_ver_cfg = cfg_data[15:0];
          REG_MAX_VERSION:       max_ver_cfg = cfg_data[15:0];
          REG_KNOWN_OPCODE_MASK: opcode_mask_cfg = cfg_data;
          REG_LEN_LIMIT:         len_limit_cfg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) decode_byte(byte_mon.data_byte);
      if (res_mon.valid && res_mon.ready) check_result();
    end
    results_due <= frame_events_due.size();
  end

endmodule

### test/tb_crc_checked_frame_decoder.sv
// Testbench top for the frame decoder: clock, reset, frame stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module tb_crc_checked_frame_decoder;
  import cfd_pkg::*;

  localparam int ITEM_TARGET = 960;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int results_due;
  int results_checked;
  int cycle_count;

  // Register values last written, so that clean frames match them.
  logic [31:0] magic_now;
  logic [15:0] min_ver_now;
  logic [15:0] max_ver_now;
  logic [63:0] mask_now;
  logic [31:0] len_limit_now;

  int      frames_sent;
  int      clean_frames;
  int      bytes_sent;
  int      settings_used;
  bit      tx_quiet;
  logic    hold_req = 1'b0;
  status_t final_flaw;

  cfd_byte_if   byte_ch ();
  cfd_result_if res_ch ();

  crc_checked_frame_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (byte_ch),
    .results     (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  cfd_frame_checker frame_check (
    .clk             (clk),
    .rst             (rst),
    .byte_mon        (byte_ch),
    .res_mon         (res_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_due     (results_due),
    .results_checked (results_checked)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] crc32c_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] flip_bits();
    return $urandom | (32'd1 << $urandom_range(0, 31));
  endfunction

  // One byte transfer on the input channel, after an optional gap.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  // Stop sending and wait until every expected result has been taken.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Writes every register while idle, then a write to an unused index that must be ignored.
  task automatic apply_setting(input logic [31:0] magic, input logic [15:0] lo,
                               input logic [15:0] hi, input logic [63:0] mask,
                               input logic [31:0] limit);
    settle();
    write_reg(REG_FRAME_MAGIC, {32'd0, magic});
    write_reg(REG_MIN_VERSION, {48'd0, lo});
    write_reg(REG_MAX_VERSION, {48'd0, hi});
    write_reg(REG_KNOWN_OPCODE_MASK, mask);
    write_reg(REG_LEN_LIMIT, {32'd0, limit});
    write_reg(CFG_IDX_W'(REG_LEN_LIMIT) + CFG_IDX_W'($urandom_range(1, 3)),
              {$urandom, $urandom});
    cfg_we <= 1'b0;
    magic_now = magic;
    min_ver_now = lo;
    max_ver_now = hi;
    mask_now = mask;
    len_limit_now = limit;
    settings_used++;
  endtask

  // Builds and sends one frame; a magic, reserved, CRC or empty-CRC flaw damages the matching field.
  task automatic send_frame(input logic [15:0] ver, input logic [15:0] opc,
                            input logic [63:0] req, input logic [31:0] len,
                            input logic [15:0] flags, input status_t flaw);
    hdr_t        h;
    logic [7:0]  body[$];
    logic [31:0] c;
    int          i;
    c = CRC_INIT;
    if (flaw == ST_OK || flaw == ST_PAYLOAD_CRC) begin
      for (i = 0; i < len; i++) begin
        body.push_back(8'($urandom));
        c = crc32c_next(c, body[i]);
      end
    end
    h = '0;
    h[3:0] = magic_now;
    h[5:4] = ver;
    h[7:6] = opc;
    h[15:8] = req;
    h[19:16] = len;
    h[21:20] = flags;
    h[27:24] = (len == 32'd0) ? 32'd0 : ~c;
    case (flaw)
      ST_MAGIC:       h[3:0] = h[3:0] ^ flip_bits();
      ST_RESERVED:    h[23:22] = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
      ST_PAYLOAD_CRC: h[27:24] = h[27:24] ^ flip_bits();
      ST_EMPTY_CRC:   h[27:24] = flip_bits();
      default: ;
    endcase
    c = CRC_INIT;
    for (i = 0; i < OFF_HCRC; i++) c = crc32c_next(c, h[i]);
    h[31:28] = ~c;
    if (flaw == ST_HDR_CRC) h[31:28] = h[31:28] ^ flip_bits();
    for (i = 0; i < HDR_BYTES; i++) put_byte(h[i]);
    foreach (body[j]) put_byte(body[j]);
    frames_sent++;
    if (flaw == ST_OK) clean_frames++;
  endtask

  // A well-formed frame that fits the current register setting.
  task automatic send_clean_frame();
    logic [15:0] ver;
    logic [15:0] opc;
    logic [31:0] len;
    int          r;
    ver = 16'($urandom_range(min_ver_now, max_ver_now));
    do opc = 16'($urandom_range(0, KNOWN_OPCODES - 1)); while (!mask_now[opc[5:0]]);
    r = $urandom_range(0, 99);
    len = (r < 20) ? 32'd0 : (r < 88) ? $urandom_range(1, 12) : $urandom_range(13, 64);
    if (len > len_limit_now) len = len_limit_now;
    tx_quiet = ($urandom_range(0, 3) == 0);
    send_frame(ver, opc, {$urandom, $urandom}, len, 16'($urandom), ST_OK);
  endtask

  task automatic random_setting();
    logic [15:0] lo;
    logic [15:0] hi;
    logic [63:0] mask;
    logic [31:0] limit;
    int          r;
    r = $urandom_range(0, 3);
    lo = (r == 0) ? 16'd0 : 16'($urandom);
    hi = (r == 1) ? 16'hFFFF : 16'($urandom_range(lo, 16'hFFFF));
    mask = ($urandom_range(0, 4) == 0) ? '1
         : {$urandom, $urandom} | (64'd1 << $urandom_range(0, 63));
    r = $urandom_range(0, 3);
    limit = (r == 0) ? $urandom_range(0, 16) : (r == 1) ? $urandom_range(17, 64)
          : (r == 2) ? 32'hFFFF_FFFF : $urandom;
    apply_setting($urandom, lo, hi, mask, limit);
  endtask

  // Result side: random stalls in stretches, plus one long hold-off on request.
  initial begin : result_side
    int stall;
    int span;
    bit rx_quiet;
    bit hold_done;
    stall = 0;
    span = 0;
    rx_quiet = 1'b0;
    hold_done = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          rx_quiet = ($urandom_range(0, 3) == 0);
          span = $urandom_range(50, 300);
        end
        span--;
        if (stall > 0) begin
          stall--;
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
          if (!rx_quiet) stall = pick_gap();
        end
      end
    end
  end

  // Input side and verdict.
  initial begin : stream_side
    logic [15:0] ver;
    logic [15:0] opc;
    logic [31:0] len;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Low extremes: only empty frames fit, all-zero and all-one header fields.
    apply_setting(32'd0, 16'd0, 16'd0, 64'd1, 32'd0);
    send_frame(16'd0, 16'd0, 64'd0, 32'd0, 16'd0, ST_OK);
    send_frame(16'd0, 16'd0, '1, 32'd0, 16'hFFFF, ST_OK);

    // High extremes: top version, highest known opcode, no length limit.
    apply_setting('1, 16'hFFFF, 16'hFFFF, 64'h8000_0000_0000_0000, '1);
    send_frame(16'hFFFF, 16'd63, '1, 32'd1, 16'hFFFF, ST_OK);

    // Long payload while the result side holds off, so the input backs up.
    hold_req <= 1'b1;
    tx_quiet = 1'b1;
    send_frame(16'hFFFF, 16'd63, {$urandom, $urandom}, 32'd60, 16'($urandom), ST_OK);

    // Random settings, each followed by a few clean frames.
    while (bytes_sent < ITEM_TARGET) begin
      random_setting();
      repeat ($urandom_range(3, 6)) begin
        send_clean_frame();
        if ($urandom_range(0, 7) == 0) settle();
      end
    end

    // One closing frame with a flaw; the error then sticks for the rest of the run.
    final_flaw = status_t'($urandom_range(ST_MAGIC, ST_EMPTY_CRC));
    apply_setting($urandom, 16'd16, 16'd32,
                  ({$urandom, $urandom} | (64'd1 << 5)) & ~(64'd1 << 9), 32'd100);
    ver = 16'd20;
    opc = 16'd5;
    len = 32'd10;
    case (final_flaw)
      ST_VERSION:   ver = $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                               : 16'($urandom_range(33, 16'hFFFF));
      ST_OPCODE:    opc = $urandom_range(0, 1) ? 16'd9
                                               : 16'($urandom_range(KNOWN_OPCODES, 16'hFFFF));
      ST_TOO_LONG:  len = $urandom_range(101, 32'hFFFF_FFFF);
      ST_EMPTY_CRC: len = 32'd0;
      default: ;
    endcase
    // An earlier check must win over an excessive length.
    if (final_flaw < ST_TOO_LONG && $urandom_range(0, 1) == 1) len = 32'd5000;
    tx_quiet = 1'b0;
    send_frame(ver, opc, {$urandom, $urandom}, len, 16'($urandom), final_flaw);

    // Bytes after the error must be dropped without any result.
    repeat (48) put_byte(8'($urandom));
    settle();
    repeat (6) @(posedge clk);

    $display("run covered %0d frames (%0d clean) under %0d register settings, %0d bytes",
             frames_sent, clean_frames, settings_used, bytes_sent);
    $display("%0d results checked, closing flaw %s, %0d mismatches",
             results_checked, final_flaw.name(), mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
